[hw/rtl/pvm_pkg.sv]
package pvm_pkg;

    localparam int VOICES_DEF       = 16;
    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam logic [16:0] GAIN_RESET = 17'd26214;
    localparam logic [7:0]  FULL_VOLUME = 8'd255;
    localparam logic [24:0] GAIN_DIVISOR = 25'd16711680;

    // floor(x / 255) equals (x * RECIP_255) >> RECIP_SHIFT for every x below 2^21.
    localparam logic [21:0] RECIP_255   = 22'd2105377;
    localparam int          RECIP_SHIFT = 29;

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_WRITE       = 4'd1,
        OP_PLAY        = 4'd2,
        OP_STOP        = 4'd3,
        OP_PAUSE       = 4'd4,
        OP_RESUME      = 4'd5,
        OP_SET_VOLUME  = 4'd6,
        OP_QUERY       = 4'd7,
        OP_PAUSE_ALL   = 4'd8,
        OP_UNPAUSE_ALL = 4'd9
    } op_t;

    // One decoded command passed from the front end to the engine.
    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] handle;
        logic [15:0] start_address;
        logic [16:0] sample_count;
        logic        loop_flag;
        logic [7:0]  volume;
        logic [15:0] sample_address;
        logic [11:0] sample_word;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MUL,
        ST_GAIN,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

[hw/rtl/pvm_front.sv]
module pvm_front
    import pvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [111:0] s_tdata,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    // Two-entry queue; the sample is pre-shifted here.
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;

    always_comb
    begin
        c.operation      = s_tdata[3:0];
        c.handle         = s_tdata[35:4];
        c.start_address  = s_tdata[51:36];
        c.sample_count   = s_tdata[68:52];
        c.loop_flag      = s_tdata[69];
        c.volume         = s_tdata[77:70];
        c.sample_address = s_tdata[93:78];
        c.sample_word    = s_tdata[109:98];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mem_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_valid && q_ready)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((s_tvalid && s_tready) ? 1 : 0)
                               - 2'((q_valid && q_ready) ? 1 : 0);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !q_ready) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !q_valid)
        else $error("empty queue shows valid");

endmodule

[hw/rtl/pvm_engine.sv]
module pvm_engine
    import pvm_pkg::*;
#(
    parameter int VOICES       = VOICES_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    input  logic [16:0] gain,
    output logic        r_valid,
    input  logic        r_ready,
    output logic [15:0] mixed_sample,
    output logic [31:0] new_handle,
    output logic        is_active,
    output logic        is_paused
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);

    logic [31:0] hnd_reg [VOICES];
    logic [15:0] st_reg  [VOICES];
    logic [16:0] len_reg [VOICES];
    logic [16:0] cur_reg [VOICES];
    logic [VOICES-1:0] lp_reg, pl_reg;
    logic [7:0]  vol_reg [VOICES];
    logic [31:0] nh_reg;
    logic [11:0] smem [SAMPLE_DEPTH];

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    logic [VW:0] idx_reg;
    logic [VW-1:0] vi;
    logic [11:0] rd_reg;
    logic [19:0] mv_reg;
    logic [36:0] prod_reg;
    logic        neg_reg;
    logic [16:0] acc_reg;       // signed running sum
    logic [15:0] q_reg;
    logic        found_reg;
    logic [VW-1:0] fv_reg;
    logic [VW-1:0] free_reg;
    logic        freef_reg;

    logic [15:0] ovs;
    logic [31:0] ovh;
    logic        ova, ovp, ov_reg;

    assign vi = idx_reg[VW-1:0];
    assign q_ready = (state_reg == ST_IDLE);

    // The sample address is the start plus cursor, modulo the depth.
    logic [AW-1:0] raddr;
    logic [16:0]   rsum;
    always_comb
    begin
        rsum  = 17'(st_reg[vi]) + (cur_reg[vi] >= len_reg[vi] ? 17'd0 : cur_reg[vi]);
        raddr = AW'(rsum);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_cmd.operation == OP_WRITE)
        begin
            smem[AW'(q_cmd.sample_address)] <= q_cmd.sample_word;
        end
        rd_reg <= smem[raddr];
    end

    // Next-state logic.
    logic vact;
    assign vact = (hnd_reg[vi] != 32'd0) && pl_reg[vi];
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (cmd_reg.operation != OP_TICK && cmd_reg.operation != OP_PLAY &&
                    (cmd_reg.operation < OP_STOP || cmd_reg.operation > OP_QUERY))
                    state_next = ST_DONE;
                else if (idx_reg == (VW+1)'(VOICES))
                    state_next = ST_DONE;
                else if (cmd_reg.operation == OP_TICK && vact &&
                         !(cur_reg[vi] >= len_reg[vi] && !lp_reg[vi]))
                    state_next = ST_READ;
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_DIV;
            ST_DIV:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_SCAN;
            ST_DONE: if (!ov_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // The scaled product is divided by 65536 with a shift and then by 255
    // with a reciprocal multiply; both floors compose to one exact floor.
    logic [11:0] mag;
    logic [42:0] recip_prod;
    logic signed [17:0] sum;
    always_comb
    begin
        mag        = rd_reg[11] ? 12'(~rd_reg + 12'd1) : rd_reg;
        recip_prod = 43'(prod_reg[36:16]) * 43'(RECIP_255);
        sum        = 18'(signed'(acc_reg)) + (neg_reg ? -18'(q_reg) : 18'(q_reg));
    end

    // Datapath and voice state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nh_reg    <= 32'd1;
            lp_reg    <= '0;
            pl_reg    <= '0;
            cmd_reg   <= '0;
            idx_reg   <= '0;
            mv_reg    <= '0;
            prod_reg  <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            q_reg     <= '0;
            found_reg <= 1'b0;
            fv_reg    <= '0;
            free_reg  <= '0;
            freef_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                hnd_reg[i] <= 32'd0;
                st_reg[i]  <= 16'd0;
                len_reg[i] <= 17'd0;
                cur_reg[i] <= 17'd0;
                vol_reg[i] <= FULL_VOLUME;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cmd_reg   <= q_cmd;
                    idx_reg   <= '0;
                    acc_reg   <= '0;
                    found_reg <= 1'b0;
                    freef_reg <= 1'b0;
                    free_reg  <= '0;
                end
                ST_SCAN:
                begin
                    if (idx_reg != (VW+1)'(VOICES))
                    begin
                        if (cmd_reg.operation == OP_TICK)
                        begin
                            if (vact && cur_reg[vi] >= len_reg[vi])
                            begin
                                if (lp_reg[vi]) cur_reg[vi] <= 17'd0;
                                else
                                begin
                                    hnd_reg[vi] <= 32'd0;
                                    pl_reg[vi]  <= 1'b0;
                                end
                            end
                        end
                        else if (cmd_reg.operation == OP_PLAY)
                        begin
                            if (hnd_reg[vi] == 32'd0 && !freef_reg)
                            begin
                                freef_reg <= 1'b1;
                                free_reg  <= vi;
                            end
                        end
                        else if (!found_reg && cmd_reg.handle != 32'd0 &&
                                 hnd_reg[vi] == cmd_reg.handle)
                        begin
                            found_reg <= 1'b1;
                            fv_reg    <= vi;
                        end
                        if (state_next != ST_READ) idx_reg <= idx_reg + (VW+1)'(1);
                    end
                end
                ST_READ: ;
                ST_MUL:
                begin
                    neg_reg <= rd_reg[11];
                    mv_reg  <= 20'(mag) * 20'(vol_reg[vi]);
                end
                ST_GAIN:
                begin
                    prod_reg <= 37'(mv_reg) * 37'(gain);
                end
                ST_DIV:
                begin
                    q_reg <= 16'(recip_prod[RECIP_SHIFT +: 14]);
                end
                ST_ACC:
                begin
                    if (sum > 18'sd32767) acc_reg <= 17'd32767;
                    else if (sum < -18'sd32768) acc_reg <= 17'h18000;
                    else acc_reg <= 17'(sum);
                    cur_reg[vi] <= cur_reg[vi] + 17'd1;
                    idx_reg     <= idx_reg + (VW+1)'(1);
                end
                ST_DONE:
                begin
                    if (!ov_reg)
                    begin
                        unique case (cmd_reg.operation)
                            OP_PLAY:
                            begin
                                hnd_reg[freef_reg ? free_reg : VW'(0)] <= nh_reg;
                                st_reg[freef_reg ? free_reg : VW'(0)]  <= cmd_reg.start_address;
                                len_reg[freef_reg ? free_reg : VW'(0)] <= cmd_reg.sample_count;
                                cur_reg[freef_reg ? free_reg : VW'(0)] <= 17'd0;
                                lp_reg[freef_reg ? free_reg : VW'(0)]  <= cmd_reg.loop_flag;
                                vol_reg[freef_reg ? free_reg : VW'(0)] <= FULL_VOLUME;
                                pl_reg[freef_reg ? free_reg : VW'(0)]  <= 1'b1;
                                nh_reg <= (nh_reg == 32'hFFFF_FFFF) ? 32'd1 : nh_reg + 32'd1;
                            end
                            OP_STOP: if (found_reg)
                            begin
                                hnd_reg[fv_reg] <= 32'd0;
                                pl_reg[fv_reg]  <= 1'b0;
                                cur_reg[fv_reg] <= 17'd0;
                            end
                            OP_PAUSE:  if (found_reg) pl_reg[fv_reg] <= 1'b0;
                            OP_RESUME: if (found_reg) pl_reg[fv_reg] <= 1'b1;
                            OP_SET_VOLUME: if (found_reg) vol_reg[fv_reg] <= cmd_reg.volume;
                            OP_PAUSE_ALL, OP_UNPAUSE_ALL:
                                for (int i = 0; i < VOICES; i++)
                                    if (hnd_reg[i] != 32'd0)
                                        pl_reg[i] <= (cmd_reg.operation == OP_UNPAUSE_ALL);
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register holds one result while the next command proceeds.
    always_comb
    begin
        ovs = (cmd_reg.operation == OP_TICK) ? acc_reg[15:0] : 16'd0;
        ovh = (cmd_reg.operation == OP_PLAY) ? nh_reg : 32'd0;
        ova = (cmd_reg.operation == OP_QUERY) && found_reg && pl_reg[fv_reg];
        ovp = (cmd_reg.operation == OP_QUERY) && found_reg && !pl_reg[fv_reg];
    end

    assign r_valid = ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg       <= 1'b0;
            mixed_sample <= '0;
            new_handle   <= '0;
            is_active    <= 1'b0;
            is_paused    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && !ov_reg)
            begin
                ov_reg       <= 1'b1;
                mixed_sample <= ovs;
                new_handle   <= ovh;
                is_active    <= ova;
                is_paused    <= ovp;
            end
            else if (r_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |=> state_reg == ST_SCAN)
        else $error("accumulate must return to scan");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_ready)
        else $error("engine took a command while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (is_active && r_valid) |-> !is_paused)
        else $error("query flags both set");

endmodule

[hw/rtl/pcm_voice_mixer_top.sv]
// Channel | Direction | Signals                    | Contents
// s       | in        | s_tvalid/s_tready/s_tdata  | one command
// m       | out       | m_tvalid/m_tready/m_tdata  | one result per command
// cfg     | in        | cfg_valid/cfg_ready/cfg_data | sfx_gain
//
// A tick scans every voice, and each playing voice then goes through read,
// magnitude times volume, gain, reciprocal divide and accumulate.
// Play and the handle commands go through the voice scan; write, pause-all,
// unpause-all and unknown codes skip it. A transfer is registered in the
// queue before it reaches the engine. Reset clears all voices and sets the
// handle counter to 1; sample memory is not cleared.
// A two-entry queue lets commands arrive while the engine is busy, and a
// result register lets the engine finish while the output is stalled.
module pcm_voice_mixer_top
    import pvm_pkg::*;
#(
    parameter int VOICES       = VOICES_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, handle, start_address, sample_count, loop_flag, volume,
    // sample_address, sample_value, zero pad
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mixed_sample, new_handle, is_active, is_paused, zero pad
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data
);

    logic        q_valid, q_ready;
    cmd_t        q_cmd;
    logic [16:0] gain_reg;
    logic [15:0] ms;
    logic [31:0] nh;
    logic        act, pau;

    // Gain writes are taken at any time; the user must send them only while idle.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            gain_reg <= cfg_data;
        end
    end

    pvm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    pvm_engine #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .gain         (gain_reg),
        .r_valid      (m_tvalid),
        .r_ready      (m_tready),
        .mixed_sample (ms),
        .new_handle   (nh),
        .is_active    (act),
        .is_paused    (pau)
    );

    assign m_tdata = {6'd0, pau, act, nh, ms};

endmodule

[verif/pcm_voice_mixer_top_tb.sv]
module pcm_voice_mixer_top_tb
    import pvm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transfer on any channel before the run is declared hung.
    // A full tick with every voice playing takes far less, so this leaves a wide
    // margin even with the random output stalls.
    localparam int IDLE_LIMIT  = 20000;
    localparam int NUM_VOICES  = 16;
    // Commands sent over the whole run, counting the directed tests.
    localparam int TOTAL_ITEMS = 600;

    // One command as the stimulus sees it.
    typedef struct {
        op_t         op;
        logic [31:0] handle;
        logic [15:0] start_addr;
        logic [16:0] count;
        logic        looping;
        logic [7:0]  volume;
        logic [15:0] wr_addr;
        logic [15:0] wr_value;
    } mix_cmd_t;

    // One result word, split into its fields.
    typedef struct packed {
        logic [15:0] mixed;
        logic [31:0] handle;
        logic        active;
        logic        paused;
    } mix_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [16:0]  cfg_data;

    pcm_voice_mixer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Mirror of the mixer state, updated as each command transfer is accepted.
    logic [16:0] mirror_gain;
    logic [31:0] mirror_handle  [NUM_VOICES];
    logic [15:0] mirror_start   [NUM_VOICES];
    logic [16:0] mirror_length  [NUM_VOICES];
    logic [16:0] mirror_cursor  [NUM_VOICES];
    logic        mirror_loops   [NUM_VOICES];
    logic [7:0]  mirror_volume  [NUM_VOICES];
    logic        mirror_playing [NUM_VOICES];
    logic [31:0] mirror_next_handle;
    logic signed [11:0] pcm_store [65536];
    bit          pcm_written [65536];

    // Results still owed by the mixer, oldest first.
    mix_res_t    pending_results[$];
    // Handles returned by play, used to aim the handle commands.
    logic [31:0] given_handles[$];

    int error_count;
    int sent_count;
    int checked_count;
    int tick_count;
    int idle_cycles;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Voice contribution: truncated toward zero.
    function automatic int scale_sample(logic signed [11:0] s, logic [7:0] vol);
        longint mag;
        longint q;
        begin
            mag = (s < 0) ? -longint'(s) : longint'(s);
            q = (mag * longint'(vol) * longint'(mirror_gain)) / longint'(GAIN_DIVISOR);
            return (s < 0) ? -int'(q) : int'(q);
        end
    endfunction

    function automatic int find_voice(logic [31:0] h);
        begin
            if (h == 32'd0)
                return -1;
            for (int i = 0; i < NUM_VOICES; i++)
                if (mirror_handle[i] == h)
                    return i;
            return -1;
        end
    endfunction

    function automatic logic [15:0] mix_one_tick();
        int acc;
        logic [15:0] addr;
        begin
            acc = 0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                if (mirror_handle[i] != 32'd0 && mirror_playing[i])
                begin
                    if (mirror_cursor[i] >= mirror_length[i])
                    begin
                        if (mirror_loops[i])
                            mirror_cursor[i] = '0;
                        else
                        begin
                            mirror_handle[i]  = '0;
                            mirror_playing[i] = 1'b0;
                            continue;
                        end
                    end
                    addr = mirror_start[i] + mirror_cursor[i][15:0];
                    acc += scale_sample(pcm_store[addr], mirror_volume[i]);
                    if (acc > 32767)
                        acc = 32767;
                    if (acc < -32768)
                        acc = -32768;
                    mirror_cursor[i] = mirror_cursor[i] + 17'd1;
                end
            end
            return acc[15:0];
        end
    endfunction

    function automatic mix_res_t apply_command(mix_cmd_t c);
        mix_res_t r;
        int v;
        begin
            r = '0;
            case (c.op)
                OP_TICK:
                    r.mixed = mix_one_tick();
                OP_WRITE:
                begin
                    pcm_store[c.wr_addr]   = c.wr_value[15:4];
                    pcm_written[c.wr_addr] = 1'b1;
                end
                OP_PLAY:
                begin
                    r.handle = mirror_next_handle;
                    mirror_next_handle = mirror_next_handle + 32'd1;
                    if (mirror_next_handle == 32'd0)
                        mirror_next_handle = 32'd1;
                    v = 0;
                    for (int i = 0; i < NUM_VOICES; i++)
                    begin
                        if (mirror_handle[i] == 32'd0)
                        begin
                            v = i;
                            break;
                        end
                    end
                    mirror_handle[v]  = r.handle;
                    mirror_start[v]   = c.start_addr;
                    mirror_length[v]  = c.count;
                    mirror_cursor[v]  = '0;
                    mirror_loops[v]   = c.looping;
                    mirror_volume[v]  = FULL_VOLUME;
                    mirror_playing[v] = 1'b1;
                end
                OP_STOP:
                begin
                    v = find_voice(c.handle);
                    if (v >= 0)
                    begin
                        mirror_handle[v]  = '0;
                        mirror_playing[v] = 1'b0;
                        mirror_cursor[v]  = '0;
                    end
                end
                OP_PAUSE:
                begin
                    v = find_voice(c.handle);
                    if (v >= 0)
                        mirror_playing[v] = 1'b0;
                end
                OP_RESUME:
                begin
                    v = find_voice(c.handle);
                    if (v >= 0)
                        mirror_playing[v] = 1'b1;
                end
                OP_SET_VOLUME:
                begin
                    v = find_voice(c.handle);
                    if (v >= 0)
                        mirror_volume[v] = c.volume;
                end
                OP_QUERY:
                begin
                    v = find_voice(c.handle);
                    if (v >= 0)
                    begin
                        r.active = mirror_playing[v];
                        r.paused = !mirror_playing[v];
                    end
                end
                OP_PAUSE_ALL, OP_UNPAUSE_ALL:
                begin
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (mirror_handle[i] != 32'd0)
                            mirror_playing[i] = (c.op == OP_UNPAUSE_ALL);
                end
                default:
                    ;
            endcase
            return r;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                return 0;
            if (roll < 94)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    // Sends one command, predicts its result once the transfer is taken,
    // then optionally leaves a gap. Valid is only dropped when a gap follows.
    task automatic send_cmd(mix_cmd_t c);
        int gap;
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {2'b00, c.wr_value, c.wr_addr, c.volume, c.looping,
                         c.count, c.start_addr, c.handle, 4'(c.op)};
            do
                @(posedge clk);
            while (!s_tready);
            pending_results.push_back(apply_command(c));
            if (c.op == OP_PLAY)
                given_handles.push_back(pending_results[$].handle);
            if (c.op == OP_TICK)
                tick_count++;
            sent_count++;
            gap = pick_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic mix_cmd_t blank_cmd(op_t op);
        mix_cmd_t c;
        begin
            c.op = op;
            c.handle = '0;
            c.start_addr = '0;
            c.count = '0;
            c.looping = 1'b0;
            c.volume = '0;
            c.wr_addr = '0;
            c.wr_value = '0;
            return c;
        end
    endfunction

    task automatic write_pcm(logic [15:0] addr, logic [15:0] value);
        mix_cmd_t c;
        begin
            c = blank_cmd(OP_WRITE);
            c.wr_addr = addr;
            c.wr_value = value;
            send_cmd(c);
        end
    endtask

    task automatic play_sound(logic [15:0] start_addr, logic [16:0] count, logic looping);
        mix_cmd_t c;
        begin
            c = blank_cmd(OP_PLAY);
            c.start_addr = start_addr;
            c.count = count;
            c.looping = looping;
            c.volume = 8'($urandom);
            send_cmd(c);
        end
    endtask

    task automatic handle_cmd(op_t op, logic [31:0] h, logic [7:0] vol);
        mix_cmd_t c;
        begin
            c = blank_cmd(op);
            c.handle = h;
            c.volume = vol;
            send_cmd(c);
        end
    endtask

    // Before a tick, every entry that a playing voice is about to read gets
    // written if it never was, so no read ever touches an unwritten entry.
    task automatic tick_once();
        logic [16:0] cur;
        logic [15:0] addr;
        begin
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                if (mirror_handle[i] != 32'd0 && mirror_playing[i])
                begin
                    cur = mirror_cursor[i];
                    if (cur >= mirror_length[i])
                    begin
                        if (!mirror_loops[i])
                            continue;
                        cur = '0;
                    end
                    addr = mirror_start[i] + cur[15:0];
                    if (!pcm_written[addr])
                        write_pcm(addr, 16'($urandom));
                end
            end
            handle_cmd(OP_TICK, 32'($urandom), 8'($urandom));
        end
    endtask

    // Holds the sender until every result has come back, then lets the
    // engine settle before the gain register is touched.
    task automatic drain_results();
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (30) @(posedge clk);
        end
    endtask

    task automatic set_gain(logic [16:0] gain);
        begin
            drain_results();
            cfg_valid <= 1'b1;
            cfg_data  <= gain;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            mirror_gain = gain;
        end
    endtask

    function automatic logic [31:0] pick_handle();
        int roll;
        begin
            roll = $urandom_range(99);
            if (roll < 10 || given_handles.size() == 0)
                return '0;
            if (roll < 75)
                return given_handles[$urandom_range(given_handles.size() - 1)];
            return 32'($urandom);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        begin
            error_count++;
            $display("MISMATCH %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        end
    endtask

    // Output ready stalls at random, drawn anew at each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) < 65) ? 1'b1 : ($urandom_range(99) < 3);
    end

    always @(posedge clk)
    begin
        mix_res_t got;
        mix_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[47:16], m_tdata[48], m_tdata[49]};
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("UNEXPECTED %0t: result 0x%0h with nothing outstanding",
                         $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (got.mixed !== want.mixed)
                    report_mismatch("mixed_sample", 32'(got.mixed), 32'(want.mixed));
                if (got.handle !== want.handle)
                    report_mismatch("new_handle", got.handle, want.handle);
                if (got.active !== want.active)
                    report_mismatch("is_active", 32'(got.active), 32'(want.active));
                if (got.paused !== want.paused)
                    report_mismatch("is_paused", 32'(got.paused), 32'(want.paused));
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("hung: %0d results still outstanding", pending_results.size());
            $display("pcm_voice_mixer_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset no voice exists: handle commands miss, a tick is
    // silent, and unknown operation codes do nothing.
    task automatic test_after_reset();
        begin
            handle_cmd(OP_QUERY, 32'd1, 8'd0);
            handle_cmd(OP_TICK, '0, '0);
            handle_cmd(op_t'(4'd10), 32'hFFFF_FFFF, 8'hFF);
            handle_cmd(op_t'(4'd15), 32'd1, 8'd0);
            handle_cmd(OP_STOP, 32'd0, 8'd0);
        end
    endtask

    // One-shot voices free themselves, zero-length loopers replay their
    // start entry, and the handle commands change pause and volume.
    task automatic test_voice_control();
        begin
            write_pcm(16'd0, 16'h7FFF);
            write_pcm(16'd1, 16'h8000);
            play_sound(16'd0, 17'd2, 1'b0);           // handle 1
            repeat (3) tick_once();
            handle_cmd(OP_QUERY, 32'd1, 8'd0);
            play_sound(16'hFFFF, 17'd0, 1'b1);        // wraps, zero length
            play_sound(16'hFFFF, 17'd3, 1'b1);        // crosses the top address
            play_sound(16'd5, 17'd0, 1'b0);           // frees on first tick
            repeat (2) tick_once();
            handle_cmd(OP_PAUSE_ALL, '0, '0);
            tick_once();
            handle_cmd(OP_QUERY, 32'd2, 8'd0);
            handle_cmd(OP_UNPAUSE_ALL, '0, '0);
            handle_cmd(OP_SET_VOLUME, 32'd2, 8'd0);
            handle_cmd(OP_SET_VOLUME, 32'd3, 8'd128);
            handle_cmd(OP_PAUSE, 32'd3, 8'd0);
            tick_once();
            handle_cmd(OP_RESUME, 32'd3, 8'd0);
            handle_cmd(OP_QUERY, 32'd3, 8'd0);
            tick_once();
            handle_cmd(OP_STOP, 32'd2, 8'd0);
            handle_cmd(OP_STOP, 32'd3, 8'd0);
            play_sound(16'd1, 17'h10000, 1'b0);       // longest sound
        end
    endtask

    // Sixteen full-scale voices at the largest gain drive the sum past both
    // rails; a seventeenth play evicts voice 0; zero gain mutes everything.
    task automatic test_saturation();
        begin
            set_gain(17'h1FFFF);
            write_pcm(16'h0010, 16'h7FF0);
            for (int i = 0; i < NUM_VOICES; i++)
                play_sound(16'h0010, 17'd1, 1'b1);
            tick_once();
            write_pcm(16'h0010, 16'h8000);
            tick_once();
            play_sound(16'h0010, 17'd1, 1'b0);
            tick_once();
            set_gain(17'd0);
            tick_once();
            set_gain(17'h10000);
            tick_once();
        end
    endtask

    // Mostly ticks and plays with handles aimed at live voices, plus noise:
    // random handles, unknown codes and writes to arbitrary addresses.
    // Runs until the whole run has sent its share of commands.
    task automatic test_random_traffic();
        mix_cmd_t c;
        int roll;
        begin
            for (int n = 0; sent_count < TOTAL_ITEMS; n++)
            begin
                if (n % 150 == 75)
                    set_gain(($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536)));
                roll = $urandom_range(99);
                if (roll < 35)
                    tick_once();
                else if (roll < 50)
                begin
                    roll = $urandom_range(99);
                    play_sound(16'($urandom),
                               (roll < 80) ? 17'($urandom_range(1, 32)) :
                               (roll < 90) ? 17'd0 : 17'($urandom_range(1, 65536)),
                               1'($urandom));
                end
                else if (roll < 60)
                    write_pcm(16'($urandom), 16'($urandom));
                else if (roll < 90)
                    handle_cmd(op_t'($urandom_range(OP_STOP, OP_QUERY)), pick_handle(),
                               8'($urandom));
                else if (roll < 96)
                    handle_cmd(($urandom_range(1) != 0) ? OP_PAUSE_ALL : OP_UNPAUSE_ALL,
                               32'($urandom), 8'($urandom));
                else
                begin
                    c = blank_cmd(op_t'($urandom_range(10, 15)));
                    c.handle = 32'($urandom);
                    c.start_addr = 16'($urandom);
                    c.count = 17'($urandom);
                    c.looping = 1'($urandom);
                    c.volume = 8'($urandom);
                    c.wr_addr = 16'($urandom);
                    c.wr_value = 16'($urandom);
                    send_cmd(c);
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        tick_count = 0;
        idle_cycles = 0;
        mirror_gain = GAIN_RESET;
        mirror_next_handle = 32'd1;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            mirror_handle[i] = '0;
            mirror_start[i] = '0;
            mirror_length[i] = '0;
            mirror_cursor[i] = '0;
            mirror_loops[i] = 1'b0;
            mirror_volume[i] = FULL_VOLUME;
            mirror_playing[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_voice_control();
        test_saturation();
        test_random_traffic();

        // Everything sent; wait for the last results, then a settling window.
        drain_results();
        $display("covered %0d commands (%0d ticks), %0d results checked, %0d plays",
                 sent_count, tick_count, checked_count, given_handles.size());
        $display("gain ran through reset, zero, unity, maximum and random values");
        if (error_count == 0)
            $display("pcm_voice_mixer_top_tb: clean");
        else
            $display("pcm_voice_mixer_top_tb: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/pvm_pkg.sv
hw/rtl/pvm_front.sv
hw/rtl/pvm_engine.sv
hw/rtl/pcm_voice_mixer_top.sv
verif/pcm_voice_mixer_top_tb.sv
